@@ rtl/core/fcte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcte_pkg
// Shared types and constants of the cluster table engine.
// ----------------------------------------------------------------------------
package fcte_pkg;

    localparam int MAX_CLUSTERS_DEF = 16384;
    localparam int SECTOR_BYTES_DEF = 512;
    localparam int LIM_W            = 17;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;
    localparam logic [1:0] CMD_FREE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PARAM  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BROKEN = 2'd3;

    localparam logic [1:0] KIND_12 = 2'd0;
    localparam logic [1:0] KIND_16 = 2'd1;
    localparam logic [1:0] KIND_32 = 2'd2;

    localparam logic [1:0] REG_KIND  = 2'd0;
    localparam logic [1:0] REG_TOTAL = 2'd1;
    localparam logic [1:0] REG_FIRST = 2'd2;

    localparam logic [27:0] EOC_12 = 28'h0000FFF;
    localparam logic [27:0] EOC_16 = 28'h000FFFF;
    localparam logic [27:0] EOC_32 = 28'hFFFFFFF;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_MUL,
        S_RD,
        S_RDW,
        S_EVAL,
        S_WR,
        S_POST,
        S_DONE
    } state_t;

endpackage

@@ rtl/core/fat_cluster_table_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_table_engine
// File allocation table engine on a local byte store.
// ----------------------------------------------------------------------------
// After reset the block clears all 4*MAX_CLUSTERS bytes of the byte store,
// one byte a cycle, and takes no item until that pass is done. Each item
// then yields one result item. Every entry access goes through the single
// byte port of the store. With N bytes per entry (two for the 12-bit and
// 16-bit formats, four for the 32-bit one), a read fetches the N bytes one
// by one, and a write fetches them and then stores the N new bytes one by
// one. Allocate reads each used entry it skips, and free reads and clears
// each entry it frees. An item is accepted only while no other item is at
// work, in the cycle after the previous result has entered the output register.
module fat_cluster_table_engine
    import fcte_pkg::*;
#(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], cluster_index[15:2], entry_data[47:16]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], result_value[29:2], freed_count[44:30], touched_sector[76:45]
    output logic [79:0] m_tdata
);

    localparam int DEPTH = MAX_CLUSTERS * 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int SH    = AW + $clog2(SECTOR_BYTES);
    localparam longint RECIP_L = ((64'd1 << SH) + SECTOR_BYTES - 1) / SECTOR_BYTES;
    localparam logic [AW:0] RECIP = (AW+1)'(RECIP_L);
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_CLUSTERS);

    state_t state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [14:0]       total_reg, total_next;
    logic [31:0]       first_reg, first_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [31:0]       data_reg, data_next;
    logic [LIM_W-1:0]  cur_reg, cur_next;
    logic [1:0]        k_reg, k_next;
    logic [7:0]        buf_reg [4];
    logic [7:0]        buf_next [4];
    logic [7:0]        nb_reg [4];
    logic [7:0]        nb_next [4];
    logic [AW-1:0]     off_reg, off_next;
    logic [2*AW:0]     prod_reg, prod_next;
    logic [31:0]       sect_reg, sect_next;
    logic [1:0]        status_reg, status_next;
    logic [27:0]       value_reg, value_next;
    logic [14:0]       freed_reg, freed_next;
    logic [27:0]       nxt_reg, nxt_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              ov_reg, ov_next;
    logic [79:0]       out_reg, out_next;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    logic [LIM_W-1:0]  limit;
    logic [1:0]        last_k;
    logic [27:0]       entry_v;
    logic [27:0]       eoc;
    logic [AW+1:0]     off_calc;
    logic [1:0]        in_cmd;
    logic [13:0]       in_ci;
    logic [31:0]       wval;

    fcte_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_cmd   = s_tdata[1:0];
    assign in_ci    = s_tdata[15:2];
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            kind_reg   <= KIND_16;
            total_reg  <= 15'd16384;
            first_reg  <= '0;
            cmd_reg    <= '0;
            data_reg   <= '0;
            cur_reg    <= '0;
            k_reg      <= '0;
            off_reg    <= '0;
            prod_reg   <= '0;
            sect_reg   <= '0;
            status_reg <= '0;
            value_reg  <= '0;
            freed_reg  <= '0;
            nxt_reg    <= '0;
            clr_reg    <= '0;
            ov_reg     <= 1'b0;
            out_reg    <= '0;
            for (int i = 0; i < 4; i++)
            begin
                buf_reg[i] <= '0;
                nb_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            total_reg  <= total_next;
            first_reg  <= first_next;
            cmd_reg    <= cmd_next;
            data_reg   <= data_next;
            cur_reg    <= cur_next;
            k_reg      <= k_next;
            off_reg    <= off_next;
            prod_reg   <= prod_next;
            sect_reg   <= sect_next;
            status_reg <= status_next;
            value_reg  <= value_next;
            freed_reg  <= freed_next;
            nxt_reg    <= nxt_next;
            clr_reg    <= clr_next;
            ov_reg     <= ov_next;
            out_reg    <= out_next;
            for (int i = 0; i < 4; i++)
            begin
                buf_reg[i] <= buf_next[i];
                nb_reg[i]  <= nb_next[i];
            end
        end
    end

    always_comb
    begin
        limit = ({2'b00, total_reg} < MAX_LIM) ? {2'b00, total_reg} : MAX_LIM;
        last_k = (kind_reg == KIND_32) ? 2'd3 : 2'd1;
        unique case (kind_reg)
            KIND_12: eoc = EOC_12;
            KIND_16: eoc = EOC_16;
            default: eoc = EOC_32;
        endcase
        unique case (kind_reg)
            KIND_12: off_calc = (AW+2)'(cur_reg) + (AW+2)'(cur_reg >> 1);
            KIND_16: off_calc = (AW+2)'({cur_reg, 1'b0});
            default: off_calc = (AW+2)'({cur_reg, 2'b00});
        endcase
        if (kind_reg == KIND_12)
        begin
            if (cur_reg[0])
            begin
                entry_v = {16'd0, buf_reg[1], buf_reg[0][7:4]};
            end
            else
            begin
                entry_v = {16'd0, buf_reg[1][3:0], buf_reg[0]};
            end
        end
        else if (kind_reg == KIND_16)
        begin
            entry_v = {12'd0, buf_reg[1], buf_reg[0]};
        end
        else
        begin
            entry_v = {buf_reg[3][3:0], buf_reg[2], buf_reg[1], buf_reg[0]};
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        total_next  = total_reg;
        first_next  = first_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        cur_next    = cur_reg;
        k_next      = k_reg;
        off_next    = off_reg;
        prod_next   = prod_reg;
        sect_next   = sect_reg;
        status_next = status_reg;
        value_next  = value_reg;
        freed_next  = freed_reg;
        nxt_next    = nxt_reg;
        clr_next    = clr_reg;
        ov_next     = ov_reg;
        out_next    = out_reg;
        for (int i = 0; i < 4; i++)
        begin
            buf_next[i] = buf_reg[i];
            nb_next[i]  = nb_reg[i];
        end
        ram_we    = 1'b0;
        ram_addr  = off_reg + AW'(k_reg);
        ram_wdata = nb_reg[k_reg];
        wval      = data_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KIND:  kind_next  = cfg_data[1:0];
                REG_TOTAL: total_next = cfg_data[14:0];
                REG_FIRST: first_next = cfg_data;
                default:   ;
            endcase
        end

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = in_cmd;
                    data_next   = s_tdata[47:16];
                    status_next = ST_OK;
                    value_next  = '0;
                    freed_next  = '0;
                    sect_next   = '0;
                    k_next      = '0;
                    state_next  = S_DONE;
                    if (kind_reg > KIND_32)
                    begin
                        status_next = ST_PARAM;
                    end
                    else
                    begin
                        case (in_cmd)
                            CMD_READ, CMD_WRITE:
                            begin
                                if (LIM_W'(in_ci) >= MAX_LIM)
                                begin
                                    status_next = ST_PARAM;
                                end
                                else
                                begin
                                    cur_next   = LIM_W'(in_ci);
                                    state_next = S_ADDR;
                                end
                            end
                            CMD_ALLOC:
                            begin
                                if (limit <= LIM_W'(2))
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    cur_next   = LIM_W'(2);
                                    state_next = S_ADDR;
                                end
                            end
                            default:
                            begin
                                if (LIM_W'(in_ci) < LIM_W'(2) || LIM_W'(in_ci) >= limit)
                                begin
                                    status_next = ST_PARAM;
                                end
                                else
                                begin
                                    cur_next   = LIM_W'(in_ci);
                                    state_next = S_ADDR;
                                end
                            end
                        endcase
                    end
                end
            end
            S_ADDR:
            begin
                off_next   = off_calc[AW-1:0];
                k_next     = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = (2*AW+1)'(off_reg) * (2*AW+1)'(RECIP);
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                buf_next[k_reg] = ram_rdata;
                if (k_reg == last_k)
                begin
                    k_next     = '0;
                    state_next = S_EVAL;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_EVAL:
            begin
                sect_next  = first_reg + 32'(prod_reg >> SH);
                state_next = S_WR;
                case (cmd_reg)
                    CMD_READ:
                    begin
                        value_next = entry_v;
                        state_next = S_DONE;
                    end
                    CMD_WRITE:
                    begin
                        wval = data_reg;
                    end
                    CMD_ALLOC:
                    begin
                        wval = {4'd0, eoc};
                        if (entry_v == '0)
                        begin
                            value_next = 28'(cur_reg);
                        end
                        else if (cur_reg + LIM_W'(1) >= limit)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_next   = cur_reg + LIM_W'(1);
                            state_next = S_ADDR;
                        end
                    end
                    default:
                    begin
                        wval = '0;
                        if (entry_v == '0)
                        begin
                            status_next = ST_BROKEN;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            nxt_next   = entry_v;
                            freed_next = freed_reg + 15'd1;
                        end
                    end
                endcase
                nb_next[0] = wval[7:0];
                nb_next[1] = wval[15:8];
                nb_next[2] = wval[23:16];
                nb_next[3] = {buf_reg[3][7:4], wval[27:24]};
                if (kind_reg == KIND_12)
                begin
                    if (cur_reg[0])
                    begin
                        nb_next[0] = {wval[3:0], buf_reg[0][3:0]};
                        nb_next[1] = wval[11:4];
                    end
                    else
                    begin
                        nb_next[1] = {buf_reg[1][7:4], wval[11:8]};
                    end
                end
            end
            S_WR:
            begin
                ram_we = 1'b1;
                if (k_reg == last_k)
                begin
                    k_next     = '0;
                    state_next = S_POST;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_POST:
            begin
                state_next = S_DONE;
                if (cmd_reg == CMD_FREE && nxt_reg != eoc)
                begin
                    if (nxt_reg < 28'd2 || nxt_reg >= 28'(limit))
                    begin
                        status_next = ST_BROKEN;
                    end
                    else
                    begin
                        cur_next   = LIM_W'(nxt_reg);
                        state_next = S_ADDR;
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    out_next   = {3'd0, sect_reg, freed_reg, value_reg, status_reg};
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/fcte_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcte_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fcte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
